// ===== rtl/ccc_pkg.sv =====
package ccc_pkg;

    // Event codes carried in the op field
    localparam logic [2:0] OP_BATCH        = 3'd0;
    localparam logic [2:0] OP_PREPARE_SENT = 3'd1;
    localparam logic [2:0] OP_CKSUM_SENT   = 3'd2;
    localparam logic [2:0] OP_CKSUM_EXEC   = 3'd3;
    localparam logic [2:0] OP_RESET        = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CADENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_CADENCE   = 2'd1;
    localparam int unsigned CFG_DATA_W = 32;

    // Register reset values
    localparam logic [15:0] OFFSET_CADENCE_RST = 16'd1;
    localparam logic [31:0] TIME_CADENCE_RST   = 32'd900000;

    // Saturation limit of one counter update
    localparam logic [15:0] UPDATE_SAT = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic        lead_flag;
        logic [62:0] batch_term;
        logic [62:0] commit_term;
        logic [63:0] acks_flushed;
        logic [63:0] acks_unflushed;
        logic [47:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [2:0] ctrl_code;
        logic       want_prepare;
        logic       want_checksum;
        logic       bad_transition;
    } t_out_word;

    typedef struct packed {
        logic [15:0] offset_cadence;
        logic [31:0] time_cadence;
    } t_cfg;

endpackage

// ===== rtl/ccc_in_if.sv =====
interface ccc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic        lead_flag;
    logic [62:0] batch_term;
    logic [62:0] commit_term;
    logic [63:0] acks_flushed;
    logic [63:0] acks_unflushed;
    logic [47:0] now_ms;

    modport source (
        output valid, op, lead_flag, batch_term, commit_term,
               acks_flushed, acks_unflushed, now_ms,
        input  ready
    );
    modport sink (
        input  valid, op, lead_flag, batch_term, commit_term,
               acks_flushed, acks_unflushed, now_ms,
        output ready
    );
endinterface

// ===== rtl/ccc_out_if.sv =====
interface ccc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] ctrl_code;
    logic       want_prepare;
    logic       want_checksum;
    logic       bad_transition;

    modport source (
        output valid, ctrl_code, want_prepare, want_checksum, bad_transition,
        input  ready
    );
    modport sink (
        input  valid, ctrl_code, want_prepare, want_checksum, bad_transition,
        output ready
    );
endinterface

// ===== rtl/ccc_cfg_regs.sv =====
module ccc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ccc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ccc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ccc_pkg::t_cfg                 o_cfg
);
    import ccc_pkg::*;

    logic [15:0] r_offset_cadence;
    logic [31:0] r_time_cadence;

    // Write the addressed register, drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_cadence <= OFFSET_CADENCE_RST;
            r_time_cadence   <= TIME_CADENCE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_OFFSET_CADENCE) begin
                r_offset_cadence <= i_cfg_data[15:0];
            end
            if (i_cfg_idx == CFG_TIME_CADENCE) begin
                r_time_cadence <= i_cfg_data;
            end
        end
    end

    assign o_cfg.offset_cadence = r_offset_cadence;
    assign o_cfg.time_cadence   = r_time_cadence;
endmodule

// ===== rtl/ccc_in_reg.sv =====
module ccc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ccc_pkg::t_in_word i_word,
    input  logic              i_take,
    output logic              o_valid,
    output ccc_pkg::t_in_word o_word
);
    import ccc_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // Accept a new word when empty or when the held word moves on
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the payload until taken
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

// ===== rtl/ccc_core.sv =====
module ccc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccc_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  ccc_pkg::t_in_word  i_word,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_ready,
    output ccc_pkg::t_out_word o_word
);
    import ccc_pkg::*;

    typedef enum logic [2:0] {
        ST_OFF       = 3'd0,
        ST_LAGGING   = 3'd1,
        ST_NOT_READY = 3'd2,
        ST_PREPARE   = 3'd3,
        ST_CHECKSUM  = 3'd4,
        ST_WAITING   = 3'd5,
        ST_FOLLOWER  = 3'd6
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    logic [16:0] r_count, n_count;
    logic [63:0] r_prior_fl, n_prior_fl;
    logic [63:0] r_prior_unfl, n_prior_unfl;
    logic [47:0] r_last, n_last;
    logic        r_out_valid;
    t_out_word   r_out, n_out;
    logic        n_bad;

    // Batch datapath signals
    logic        follower;
    logic [63:0] base_fl, base_unfl;
    logic [16:0] base_count;
    logic [47:0] base_last;
    logic [63:0] df, du;
    logic        fl_lt, unfl_lt, big;
    logic [31:0] df_lo, du_lo;
    logic [32:0] dsum;
    logic [15:0] upd;
    logic [17:0] cnt_sum;
    logic [16:0] cap, capped;
    logic [48:0] limit;
    logic        due;
    logic        catchup_state;

    // Advance when a word is held and the result register is free
    assign o_take = i_valid && (!r_out_valid || i_ready);

    // Counter update, count cap and due check for a caught-up batch
    always_comb begin
        follower   = (r_state == ST_FOLLOWER);
        base_fl    = follower ? i_word.acks_flushed   : r_prior_fl;
        base_unfl  = follower ? i_word.acks_unflushed : r_prior_unfl;
        base_count = follower ? 17'd0 : r_count;
        base_last  = follower ? i_word.now_ms : r_last;

        fl_lt   = i_word.acks_flushed < base_fl;
        unfl_lt = i_word.acks_unflushed < base_unfl;
        df      = i_word.acks_flushed - base_fl;
        du      = i_word.acks_unflushed - base_unfl;
        big     = (!fl_lt && (|df[63:32])) || (!unfl_lt && (|du[63:32]));
        df_lo   = fl_lt ? 32'd0 : df[31:0];
        du_lo   = unfl_lt ? 32'd0 : du[31:0];
        dsum    = {1'b0, df_lo} + {1'b0, du_lo};
        upd     = (big || (|dsum[32:16])) ? UPDATE_SAT : dsum[15:0];

        cnt_sum = {1'b0, base_count} + {2'b00, upd};
        cap     = {i_cfg.offset_cadence, 1'b0};
        capped  = (cnt_sum > {1'b0, cap}) ? cap : cnt_sum[16:0];

        limit   = {1'b0, base_last} + {17'd0, i_cfg.time_cadence};
        due     = ({1'b0, i_word.now_ms} > limit) ||
                  (capped >= {1'b0, i_cfg.offset_cadence});

        catchup_state = (r_state == ST_OFF) || (r_state == ST_FOLLOWER) ||
                        (r_state == ST_LAGGING) || (r_state == ST_NOT_READY);
    end

    // Next state per event
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_prior_fl   = r_prior_fl;
        n_prior_unfl = r_prior_unfl;
        n_last       = r_last;
        n_bad        = 1'b0;
        case (i_word.op)
            OP_BATCH: begin
                if (!i_word.lead_flag) begin
                    n_state = ST_FOLLOWER;
                end else if (catchup_state) begin
                    if (i_word.batch_term != i_word.commit_term) begin
                        n_state = ST_LAGGING;
                    end else begin
                        n_prior_fl   = i_word.acks_flushed;
                        n_prior_unfl = i_word.acks_unflushed;
                        n_count      = capped;
                        n_last       = base_last;
                        n_state      = due ? ST_PREPARE : ST_NOT_READY;
                    end
                end
            end
            OP_PREPARE_SENT: begin
                if (r_state == ST_PREPARE) begin
                    n_state = ST_CHECKSUM;
                end else begin
                    n_bad = 1'b1;
                end
            end
            OP_CKSUM_SENT: begin
                if (r_state == ST_CHECKSUM) begin
                    n_state = ST_WAITING;
                end else begin
                    n_bad = 1'b1;
                end
            end
            OP_CKSUM_EXEC: begin
                if (r_state == ST_WAITING) begin
                    n_state = ST_NOT_READY;
                end
            end
            OP_RESET: begin
                n_count      = 17'd0;
                n_last       = i_word.now_ms;
                n_prior_fl   = i_word.acks_flushed;
                n_prior_unfl = i_word.acks_unflushed;
                n_state      = ST_OFF;
            end
            default: begin
                n_bad = 1'b1;
            end
        endcase

        n_out.ctrl_code      = n_state;
        n_out.want_prepare   = (n_state == ST_PREPARE);
        n_out.want_checksum  = (n_state == ST_CHECKSUM);
        n_out.bad_transition = n_bad;
    end

    // Hold state and the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_OFF;
            r_count      <= 17'd0;
            r_prior_fl   <= 64'd0;
            r_prior_unfl <= 64'd0;
            r_last       <= 48'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_take) begin
                r_state      <= n_state;
                r_count      <= n_count;
                r_prior_fl   <= n_prior_fl;
                r_prior_unfl <= n_prior_unfl;
                r_last       <= n_last;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Load the result payload with each advanced word
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;
endmodule

// ===== rtl/checksum_cadence_controller_top.sv =====
// An accepted word passes through the input register, then the result register, which
// loads it when that register is empty or the output side is ready.
// Throughput: one word per cycle unless the output stalls; the state update is a single
// pass through counter subtract, count cap and due compare between input and result regs.
// Reset (i_rst_n low, synchronous): state off, counters and times zero, both pipeline
// registers empty, offset_cadence 1 and time_cadence 900000.
module checksum_cadence_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ccc_in_if.sink                         i_in,
    ccc_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [ccc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ccc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ccc_pkg::*;

    t_cfg      cfg;
    t_in_word  in_word, held_word;
    t_out_word out_word;
    logic      held_valid;
    logic      take;

    // Pack the input payload
    assign in_word.op             = i_in.op;
    assign in_word.lead_flag      = i_in.lead_flag;
    assign in_word.batch_term     = i_in.batch_term;
    assign in_word.commit_term    = i_in.commit_term;
    assign in_word.acks_flushed   = i_in.acks_flushed;
    assign in_word.acks_unflushed = i_in.acks_unflushed;
    assign in_word.now_ms         = i_in.now_ms;

    ccc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ccc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_word  (in_word),
        .i_take  (take),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    ccc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (held_valid),
        .i_word  (held_word),
        .o_take  (take),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_word  (out_word)
    );

    // Unpack the result payload
    assign o_out.ctrl_code      = out_word.ctrl_code;
    assign o_out.want_prepare   = out_word.want_prepare;
    assign o_out.want_checksum  = out_word.want_checksum;
    assign o_out.bad_transition = out_word.bad_transition;
endmodule
